// ===== sv/rar_pkg.sv =====
// package: widths, operation codes and handshake structs for the rational reduce unit
`default_nettype none
package rar_pkg;

  localparam int OPB         = 16;
  localparam int PROD_W      = 2 * OPB;
  localparam int SUM_W       = PROD_W + 1;
  localparam int MAG_W       = PROD_W;
  localparam int DIFF_W      = MAG_W + 2;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int OUT_W       = 32;
  localparam int IN_FIELDS_W = 2 + 4 * OPB;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * OUT_W;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_DIV = 2'd2,
    OP_MUL = 2'd3
  } op_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
  } red_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] num_q;
    logic [MAG_W-1:0] den_q;
  } red_rsp_t;

endpackage
`default_nettype wire

// ===== sv/rar_mul.sv =====
// registered signed operand multiplier shared by all cross products
`default_nettype none
module rar_mul
  import rar_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [OPB-1:0]    a,
  input  wire logic signed [OPB-1:0]    b,
  output      logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== sv/rar_gcd.sv =====
// reduction engine: binary gcd then two restoring divisions on one shared subtractor
`default_nettype none
module rar_gcd
  import rar_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire red_req_t req,
  output      red_rsp_t rsp
);

  typedef enum logic [3:0] {
    G_IDLE  = 4'b0001,
    G_STRIP = 4'b0010,
    G_STEP  = 4'b0100,
    G_DIV   = 4'b1000
  } gstate_t;

  gstate_t          state;
  logic [MAG_W-1:0] a;
  logic [MAG_W-1:0] b;
  logic [CNT_W-1:0] k;
  logic [MAG_W-1:0] orig_n;
  logic [MAG_W-1:0] orig_d;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] q;
  logic [MAG_W-1:0] qa;
  logic [MAG_W-1:0] qd;
  logic [CNT_W-1:0] cnt;
  logic             sel;
  logic             done;

  logic [DIFF_W-1:0] x_op;
  logic [DIFF_W-1:0] y_op;
  logic [DIFF_W-1:0] diff;
  logic              neg;
  logic [MAG_W-1:0]  gcd_val;
  logic [MAG_W:0]    shifted;
  logic [MAG_W-1:0]  q_next;

  assign gcd_val = b << k;
  assign shifted = {rem, q[MAG_W-1]};

  // the one subtractor: a - b during the gcd loop, trial subtract during division
  always_comb begin
    if (state == G_DIV) begin
      x_op = {1'b0, shifted};
      y_op = {2'b00, gcd_val};
    end else begin
      x_op = {2'b00, a};
      y_op = {2'b00, b};
    end
    diff = x_op - y_op;
    neg  = diff[DIFF_W-1];
  end

  assign q_next = {q[MAG_W-2:0], ~neg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        G_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            a      <= req.num_mag;
            b      <= req.den_mag;
            orig_n <= req.num_mag;
            orig_d <= req.den_mag;
            k      <= '0;
            state  <= G_STRIP;
          end
        end
        G_STRIP: begin
          // pull out the common power of two
          if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else begin
            state <= G_STEP;
          end
        end
        G_STEP: begin
          if (a == '0) begin
            rem   <= '0;
            q     <= orig_n;
            cnt   <= '0;
            sel   <= 1'b0;
            state <= G_DIV;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (!neg) begin
            a <= {1'b0, diff[MAG_W-1:1]};
          end else begin
            // keep a >= b for the next subtract
            a <= b;
            b <= a;
          end
        end
        G_DIV: begin
          // count wraps to zero for the second division
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAG_W - 1)) begin
            if (!sel) begin
              qa  <= q_next;
              q   <= orig_d;
              rem <= '0;
              sel <= 1'b1;
            end else begin
              qd    <= q_next;
              done  <= 1'b1;
              state <= G_IDLE;
            end
          end else begin
            rem <= neg ? shifted[MAG_W-1:0] : diff[MAG_W-1:0];
            q   <= q_next;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.num_q = qa;
  assign rsp.den_q = qd;

endmodule
`default_nettype wire

// ===== sv/rational_arithmetic_reduce_unit.sv =====
// top level: operand capture, cross products, sign handling and result register
//
//   channel | direction | tdata (low bit up)                      | tuser
//   s_axis  | in        | func, num_a, den_a, num_b, den_b, zeros | -
//   m_axis  | out       | num_out, den_out                        | is_whole, zero_den
//
// one item at a time: products, then sign split, then the gcd engine
// (strip of common twos, binary gcd loop over the two 32-bit magnitudes,
// two divisions), then into the output register.
// a zero numerator or denominator skips the gcd engine.
// rst is synchronous and clears the sequencers and m_axis_tvalid.
// a finished result waits in the output register; the next item may enter meanwhile.
`default_nettype none
module rational_arithmetic_reduce_unit
  import rar_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // func, num_a, den_a, num_b, den_b
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,  // num_out, den_out
  output      logic [OUT_TUSER_W-1:0] m_axis_tuser   // is_whole, zero_den
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SIGN = 5'b00100,
    S_RED  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                   state;
  op_t                      op;
  logic signed [OPB-1:0]    na;
  logic signed [OPB-1:0]    da;
  logic signed [OPB-1:0]    nb;
  logic signed [OPB-1:0]    db;
  logic [1:0]               cnt;
  logic signed [SUM_W-1:0]  n_acc;
  logic signed [PROD_W-1:0] d_reg;
  logic [MAG_W-1:0]         mn;
  logic [MAG_W-1:0]         md;
  logic                     nneg;
  logic                     dneg;
  logic                     whole;
  logic                     zden;

  logic signed [OPB-1:0]    ma;
  logic signed [OPB-1:0]    mb;
  logic signed [PROD_W-1:0] p;
  logic signed [SUM_W-1:0]  p_ext;
  logic [SUM_W-1:0]         n_abs;
  logic [PROD_W-1:0]        d_abs;
  logic                     n_zero;
  logic                     d_zero;
  logic                     out_free;
  logic [OUT_W-1:0]         num_out;
  logic [OUT_W-1:0]         den_out;
  red_req_t                 req;
  red_rsp_t                 rsp;

  rar_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (p)
  );

  rar_gcd u_gcd (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // product issue order: numerator term, second term or denominator, denominator
  always_comb begin
    unique case (cnt)
      2'd0: begin
        ma = na;
        mb = (op == OP_MUL) ? nb : db;
      end
      2'd1: begin
        ma = da;
        mb = (op == OP_MUL) ? db : nb;
      end
      default: begin
        ma = da;
        mb = db;
      end
    endcase
  end

  assign p_ext  = {p[PROD_W-1], p};
  assign n_abs  = n_acc[SUM_W-1] ? -n_acc : n_acc;
  assign d_abs  = d_reg[PROD_W-1] ? -d_reg : d_reg;
  assign n_zero = (n_acc == '0);
  assign d_zero = (d_reg == '0);

  assign req.start   = (state == S_SIGN) && !n_zero && !d_zero;
  assign req.num_mag = n_abs[MAG_W-1:0];
  assign req.den_mag = MAG_W'(d_abs);

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign num_out  = nneg ? OUT_W'(~mn + 1'b1) : OUT_W'(mn);
  assign den_out  = dneg ? OUT_W'(~md + 1'b1) : OUT_W'(md);

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // s_out reloads the register itself when it takes over a finished transfer
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= op_t'(s_axis_tdata[1:0]);
            na    <= s_axis_tdata[2 +: OPB];
            da    <= s_axis_tdata[2 + OPB +: OPB];
            nb    <= s_axis_tdata[2 + 2 * OPB +: OPB];
            db    <= s_axis_tdata[2 + 3 * OPB +: OPB];
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          // multiplier output is registered, so it belongs to the previous issue count
          unique case (cnt)
            2'd0: ;
            2'd1: n_acc <= p_ext;
            2'd2: begin
              unique case (op)
                OP_ADD:  n_acc <= n_acc + p_ext;
                OP_SUB:  n_acc <= n_acc - p_ext;
                default: d_reg <= p;
              endcase
            end
            default: begin
              if (op == OP_ADD || op == OP_SUB) begin
                d_reg <= p;
              end
              state <= S_SIGN;
            end
          endcase
        end
        S_SIGN: begin
          mn    <= n_abs[MAG_W-1:0];
          md    <= MAG_W'(d_abs);
          nneg  <= n_acc[SUM_W-1];
          dneg  <= d_reg[PROD_W-1];
          zden  <= d_zero;
          whole <= n_zero && !d_zero;
          state <= (n_zero || d_zero) ? S_OUT : S_RED;
        end
        S_RED: begin
          if (rsp.done) begin
            mn    <= rsp.num_q;
            md    <= rsp.den_q;
            // reduced terms are coprime, so the division is exact only for unit denominator
            whole <= (rsp.den_q == MAG_W'(1));
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {den_out, num_out};
            m_axis_tuser  <= {zden, whole};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/rar_chk.sv =====
// port checker for the rational reduce unit, bound to the top level
`default_nettype none
module rar_chk
  import rar_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic [OUT_W-1:0] den_w;
  logic [OUT_W-1:0] num_w;

  assign num_w = m_axis_tdata[OUT_W-1:0];
  assign den_w = m_axis_tdata[OUT_TDATA_W-1:OUT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> den_w == '0 && !m_axis_tuser[0])
    else $error("zero denominator flag with bad payload");

  a_whole_unit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && num_w != '0 |->
      den_w == OUT_W'(1) || den_w == '1)
    else $error("whole number with non-unit denominator");

endmodule

bind rational_arithmetic_reduce_unit rar_chk u_rar_chk (.*);
`default_nettype wire

// ===== tb/sv/rational_arithmetic_reduce_unit_tb.sv =====
// testbench for the rational reduce unit: self-predicting stream driver and result checker
module rational_arithmetic_reduce_unit_tb;
  import rar_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] num;
    logic [OUT_W-1:0] den;
    logic             whole;
    logic             zden;
  } frac_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  frac_res_t pending_fracs[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        whole_seen = 0;
  int        zden_seen = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  int        rx_hold = 0;

  rational_arithmetic_reduce_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // cross products at 64 bits, then divide out the gcd of the magnitudes
  function automatic frac_res_t reduce_fraction(op_t op, logic [OPB-1:0] na_b, da_b,
                                                nb_b, db_b);
    longint          na, da, nb, db, n, d;
    longint unsigned mn, md, a, b, t;
    frac_res_t       r;
    na = longint'($signed(na_b));
    da = longint'($signed(da_b));
    nb = longint'($signed(nb_b));
    db = longint'($signed(db_b));
    case (op)
      OP_ADD: begin n = na * db + da * nb; d = da * db; end
      OP_SUB: begin n = na * db - da * nb; d = da * db; end
      OP_DIV: begin n = na * db;           d = da * nb; end
      default: begin n = na * nb;          d = da * db; end
    endcase
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    r.whole = 1'b0;
    r.zden  = 1'b0;
    if (md == 0) begin
      r.zden = 1'b1;
    end else if (mn == 0) begin
      r.whole = 1'b1;
    end else begin
      a = mn;
      b = md;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      mn = mn / a;
      md = md / a;
      r.whole = (mn % md == 0);
    end
    r.num = (n < 0) ? OUT_W'(-mn) : OUT_W'(mn);
    r.den = (d < 0) ? OUT_W'(-md) : OUT_W'(md);
    return r;
  endfunction

  function automatic logic [OPB-1:0] rand_operand();
    logic signed [OPB-1:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7fff;
          1: v = 16'h8001;
          2: v = 16'h8000;
          3: v = 16'h0001;
          default: v = 16'hffff;
        endcase
      end
      2, 3, 4, 5: begin
        v = OPB'($urandom_range(0, 40));
        v = v - 16'sd20;
      end
      default: v = OPB'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // offer one item and hold it until the transfer; tvalid stays up if the next gap is zero
  task automatic send_item(input op_t op, input logic [OPB-1:0] na, da, nb, db);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, db, nb, da, na, op};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    pending_fracs.push_back(reduce_fraction(op, na, da, nb, db));
    items_sent++;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    stop_input();
    while (pending_fracs.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      send_item(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
    end
  endtask

  task automatic test_each_op();
    send_item(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(OP_DIV, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(OP_MUL, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(OP_ADD, 16'sd3, 16'sd4, 16'sd5, 16'sd4);
    send_item(OP_MUL, 16'sd6, 16'sd4, 16'sd2, 16'sd3);
  endtask

  task automatic test_special_cases();
    // zero denominator, no reduction
    send_item(OP_ADD, 16'sd4, 16'sd0, 16'sd2, 16'sd6);
    send_item(OP_MUL, 16'sd4, 16'sd8, 16'sd2, 16'sd0);
    send_item(OP_DIV, 16'sd4, 16'sd8, 16'sd0, 16'sd6);
    send_item(OP_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    // zero numerator stays unreduced
    send_item(OP_SUB, 16'sd3, 16'sd6, 16'sd3, 16'sd6);
    send_item(OP_MUL, 16'sd0, 16'sd9, 16'sd5, 16'sd3);
    // whole results and signs left as they fall
    send_item(OP_DIV, 16'sd8, 16'sd1, 16'sd2, 16'sd1);
    send_item(OP_MUL, -16'sd3, -16'sd4, 16'sd8, -16'sd6);
    send_item(OP_ADD, -16'sd1, 16'sd2, 16'sd1, -16'sd2);
  endtask

  task automatic test_extremes();
    send_item(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(OP_ADD, 16'h7fff, 16'h8001, 16'h7fff, 16'h8001);
    send_item(OP_SUB, 16'h7fff, 16'h8001, 16'h8001, 16'h7fff);
    send_item(OP_DIV, 16'h8000, 16'h0001, 16'h0001, 16'h8000);
    send_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(OP_SUB, 16'hffff, 16'h7ffe, 16'h0001, 16'h7fff);
    send_item(OP_DIV, 16'h7fff, 16'hffff, 16'h8001, 16'h0001);
  endtask

  // sender waits for every result between short batches
  task automatic test_drain_pause();
    repeat (4) begin
      send_random(3);
      wait_for_drain();
    end
  endtask

  // receiver holds off long enough that the unit must stall its input
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 3000;
    send_random(20);
    tx_idle = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_random_no_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_random(150);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_idle();
    send_random(950);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_op();
    test_special_cases();
    test_extremes();
    test_drain_pause();
    test_backpressure();
    test_random_no_idle();
    test_random_idle();
    wait_for_drain();
    repeat (400) @(posedge clk);
    $display("sent %0d items over all four operations, %0d results checked", items_sent,
             results_checked);
    $display("including %0d whole and %0d zero-denominator results, long output stall",
             whole_seen, zden_seen);
    if (mismatches == 0) begin
      $display("** rational_arithmetic_reduce_unit: PASSED **");
    end else begin
      $display("** rational_arithmetic_reduce_unit: FAILED **");
    end
    $finish;
  end

  // receiver: random wait per result, or one long hold when asked
  initial begin
    int gap;
    forever begin
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 18) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fracs.size() == 0) begin
        report_mismatch($sformatf("unexpected result transfer tdata=%h tuser=%b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_fracs.pop_front();
        results_checked++;
        if (want.whole) whole_seen++;
        if (want.zden) zden_seen++;
        if (m_axis_tdata[OUT_W-1:0] !== want.num)
          report_mismatch($sformatf("num_out got %h want %h", m_axis_tdata[OUT_W-1:0],
                                    want.num));
        if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.den)
          report_mismatch($sformatf("den_out got %h want %h",
                                    m_axis_tdata[2*OUT_W-1:OUT_W], want.den));
        if (m_axis_tuser[0] !== want.whole)
          report_mismatch($sformatf("is_whole got %b want %b", m_axis_tuser[0], want.whole));
        if (m_axis_tuser[1] !== want.zden)
          report_mismatch($sformatf("zero_den got %b want %b", m_axis_tuser[1], want.zden));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_fracs.size());
    $display("** rational_arithmetic_reduce_unit: FAILED **");
    $finish;
  end

endmodule
